>>> design/pcgp_pkg.sv
// Package for the pad cluster Gaussian position block: widths, log table, codes.
package pcgp_pkg;
	localparam int SampleW = 9;
	localparam int PadSumW = 14;
	localparam int TotalW  = 20;
	localparam int LogW    = 20;
	localparam int DivW    = 37;
	localparam int PadSumMax = 8191;
	localparam int PadSumMin = -8192;
	localparam int TotalMax  = 524287;
	localparam int TotalMin  = -524288;

	typedef logic [16:0] tab_t;

	function automatic tab_t log_tab(input logic [5:0] i);
		tab_t t;
		case (i)
			6'd0:  t = 17'd0;     6'd1:  t = 17'd2909;  6'd2:  t = 17'd5732;
			6'd3:  t = 17'd8473;  6'd4:  t = 17'd11136; 6'd5:  t = 17'd13727;
			6'd6:  t = 17'd16248; 6'd7:  t = 17'd18704; 6'd8:  t = 17'd21098;
			6'd9:  t = 17'd23433; 6'd10: t = 17'd25711; 6'd11: t = 17'd27936;
			6'd12: t = 17'd30109; 6'd13: t = 17'd32234; 6'd14: t = 17'd34312;
			6'd15: t = 17'd36346; 6'd16: t = 17'd38336; 6'd17: t = 17'd40286;
			6'd18: t = 17'd42196; 6'd19: t = 17'd44068; 6'd20: t = 17'd45904;
			6'd21: t = 17'd47705; 6'd22: t = 17'd49472; 6'd23: t = 17'd51207;
			6'd24: t = 17'd52911; 6'd25: t = 17'd54584; 6'd26: t = 17'd56229;
			6'd27: t = 17'd57845; 6'd28: t = 17'd59434; 6'd29: t = 17'd60997;
			6'd30: t = 17'd62534; 6'd31: t = 17'd64047; 6'd32: t = 17'd65536;
			default: t = 17'd0;
		endcase
		return t;
	endfunction
endpackage

>>> design/pad_cluster_gaussian_position.sv
// Top level: pad accumulation and cluster-end offset/fraction sequencer.
// A sample that does not end a cluster is taken and leaves ready high.
// A cluster-end sample starts a sequencer: six logarithms, then two offset divisions
// (each skipped if its denominator is not positive) and six fraction divisions share
// one restoring divider; the result beat is offered as the last fraction is stored.
// One sample per cycle while idle; ready returns right after the result beat is taken.
// Reset: arst_n clears all control and accumulation state; pad_width returns to 1000.
module pad_cluster_gaussian_position #(
	parameter int MAX_SAMPLES = 32,
	parameter int MAX_PADS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [8:0] sample,
	input  logic last_sample,
	input  logic last_pad,
	input  logic normal_stop,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data,
	output logic out_valid,
	input  logic out_ready,
	output logic spectrum_valid,
	output logic signed [19:0] cluster_charge,
	output logic charge_pos_valid,
	output logic signed [15:0] charge_offset,
	output logic [15:0] charge_frac_left,
	output logic [15:0] charge_frac_mid,
	output logic [15:0] charge_frac_right,
	output logic peak_pos_valid,
	output logic signed [15:0] peak_offset,
	output logic [15:0] peak_frac_left,
	output logic [15:0] peak_frac_mid,
	output logic [15:0] peak_frac_right
);
	import pcgp_pkg::*;

	localparam int SCW = $clog2(MAX_SAMPLES + 1);
	localparam int PCW = $clog2(MAX_PADS + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LOGN = 4'd1;
	localparam logic [3:0] ST_LOGF = 4'd2;
	localparam logic [3:0] ST_OFFM = 4'd3;
	localparam logic [3:0] ST_OFFD = 4'd4;
	localparam logic [3:0] ST_OFFE = 4'd5;
	localparam logic [3:0] ST_FRD  = 4'd6;
	localparam logic [3:0] ST_FRE  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	localparam logic [5:0] STEP_LOAD = 6'd63;

	logic [15:0] width_q;
	logic signed [PadSumW-1:0] psum_q;
	logic signed [SampleW-1:0] ppeak_q;
	logic [SCW-1:0] scnt_q;
	logic [PCW-1:0] pcnt_q;
	logic signed [TotalW-1:0] tot_q;
	logic signed [PadSumW-1:0] ch_q [3];
	logic signed [SampleW-1:0] pk_q [3];
	logic [3:0] st_q;
	logic [2:0] sel_q;
	logic [5:0] step_q;
	logic [LogW-1:0] lg_q [6];
	logic [13:0] lv_q;
	logic [3:0] ln_q;
	logic cok_q, pok_q;
	logic [1:0] grp_q;
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [DivW-1:0] quo_q;
	logic [DivW-1:0] dvd_q;
	logic neg_q;

	// pad accumulation
	logic acc_en;
	logic signed [PadSumW:0] psum_n;
	logic signed [PadSumW-1:0] psum_sat;
	logic signed [SampleW-1:0] peak_n;
	logic signed [TotalW:0] tot_n;
	logic signed [TotalW-1:0] tot_sat;
	logic take;

	assign in_ready = (st_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign take = in_valid && in_ready;
	assign acc_en = scnt_q < SCW'(MAX_SAMPLES);

	always_comb begin
		psum_n = (PadSumW+1)'(psum_q) + (PadSumW+1)'(sample);
		if (!acc_en) psum_sat = psum_q;
		else if (psum_n > (PadSumW+1)'(PadSumMax)) psum_sat = PadSumW'(PadSumMax);
		else if (psum_n < (PadSumW+1)'(PadSumMin)) psum_sat = PadSumW'(PadSumMin);
		else psum_sat = psum_n[PadSumW-1:0];
		peak_n = (acc_en && sample > ppeak_q) ? sample : ppeak_q;
		tot_n = (TotalW+1)'(tot_q) + (TotalW+1)'(psum_sat);
		if (tot_n > (TotalW+1)'(TotalMax)) tot_sat = TotalW'(TotalMax);
		else if (tot_n < (TotalW+1)'(TotalMin)) tot_sat = TotalW'(TotalMin);
		else tot_sat = tot_n[TotalW-1:0];
	end

	// log operand select and validity
	logic [13:0] lsrc;
	always_comb begin
		case (sel_q)
			3'd0: lsrc = 14'(ch_q[0]);
			3'd1: lsrc = 14'(ch_q[1]);
			3'd2: lsrc = 14'(ch_q[2]);
			3'd3: lsrc = 14'({5'd0, pk_q[0]});
			3'd4: lsrc = 14'({5'd0, pk_q[1]});
			default: lsrc = 14'({5'd0, pk_q[2]});
		endcase
	end

	logic [5:0] li;
	logic [9:0] lr;
	logic [14:0] lm;
	logic [16:0] t0, t1;
	logic [26:0] lprod;
	always_comb begin
		lm = 15'(lv_q) << (4'd14 - ln_q);
		li = {1'b0, lm[13:9]};
		lr = {lm[8:0], 1'b0};
		t0 = log_tab(li);
		t1 = log_tab(li + 6'd1);
		lprod = 27'(t1 - t0) * 27'(lr);
	end

	logic signed [LogW+1:0] num_o, den_o;
	logic [LogW+1:0] anum_o;
	logic [2:0] b;
	logic [TotalW-1:0] fwhole;
	logic [TotalW-1:0] fpart;
	logic [32:0] trial;
	logic [DivW-1:0] oprod;
	always_comb begin
		b = (grp_q == 2'd1) ? 3'd3 : 3'd0;
		num_o = (LogW+2)'(lg_q[b+3'd2]) - (LogW+2)'(lg_q[b]);
		den_o = ((LogW+2)'(lg_q[b+3'd1]) <<< 1) - (LogW+2)'(lg_q[b]) -
			(LogW+2)'(lg_q[b+3'd2]);
		anum_o = num_o < 0 ? -num_o : num_o;
		oprod = width_q * anum_o[LogW-1:0];
		fwhole = (grp_q[0] == 1'b0) ? tot_q :
			TotalW'(pk_q[0]) + TotalW'(pk_q[1]) + TotalW'(pk_q[2]);
		case (sel_q)
			3'd0: fpart = grp_q[0] ? TotalW'(pk_q[0]) : TotalW'(ch_q[0]);
			3'd1: fpart = grp_q[0] ? TotalW'(pk_q[1]) : TotalW'(ch_q[1]);
			default: fpart = grp_q[0] ? TotalW'(pk_q[2]) : TotalW'(ch_q[2]);
		endcase
		trial = {rem_q[31:0], dvd_q[DivW-1]} - den_q;
	end

	logic pos3, cgate, pgate;
	assign pos3 = ch_q[0] > 0 && ch_q[1] > 0 && ch_q[2] > 0;
	assign cgate = pcnt_q == PCW'(3) && pos3 && ch_q[0] <= ch_q[1] &&
		ch_q[2] <= ch_q[1] && tot_q > 0;
	assign pgate = pcnt_q == PCW'(3) && pos3 && pk_q[0] > 0 && pk_q[1] > 0 &&
		pk_q[2] > 0 && pk_q[0] <= pk_q[1] && pk_q[2] <= pk_q[1];

	logic [15:0] fr_q [6];
	logic signed [15:0] co_q, po_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 16'd1000;
			psum_q <= '0;
			ppeak_q <= -9'sd255;
			scnt_q <= '0;
			pcnt_q <= '0;
			tot_q <= '0;
			for (int k = 0; k < 3; k++) begin
				ch_q[k] <= '0;
				pk_q[k] <= '0;
			end
			st_q <= ST_IDLE;
			out_valid <= 1'b0;
			sel_q <= '0;
			step_q <= '0;
			grp_q <= '0;
			cok_q <= 1'b0;
			pok_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) width_q <= cfg_data;
			case (st_q)
				ST_IDLE: begin
					if (take) begin
						if (!last_sample) begin
							psum_q <= psum_sat;
							ppeak_q <= peak_n;
							if (acc_en) scnt_q <= scnt_q + SCW'(1);
						end else begin
							psum_q <= '0;
							ppeak_q <= -9'sd255;
							scnt_q <= '0;
							if (pcnt_q < PCW'(MAX_PADS)) begin
								if (pcnt_q < PCW'(3)) begin
									ch_q[pcnt_q[1:0]] <= psum_sat;
									pk_q[pcnt_q[1:0]] <= peak_n;
								end
								if (normal_stop) tot_q <= tot_sat;
								pcnt_q <= pcnt_q + PCW'(1);
							end
							if (last_pad) begin
								st_q <= ST_LOGN;
								sel_q <= '0;
							end
						end
					end
				end
				ST_LOGN: begin
					// leading-one search, one bit a step
					cok_q <= cgate;
					pok_q <= pgate;
					lv_q <= lsrc;
					ln_q <= '0;
					step_q <= '0;
					st_q <= ST_LOGF;
				end
				ST_LOGF: begin
					if (step_q < 6'd13 && (lv_q >> (ln_q + 4'd1)) != 14'd0) begin
						ln_q <= ln_q + 4'd1;
						step_q <= step_q + 6'd1;
					end else begin
						lg_q[sel_q] <= (lv_q == 14'd0) ? '0 :
							LogW'({ln_q, 16'd0}) + LogW'(t0) + LogW'(lprod >> 10);
						if (sel_q == 3'd5) begin
							sel_q <= '0;
							grp_q <= 2'd0;
							st_q <= ST_OFFM;
						end else begin
							sel_q <= sel_q + 3'd1;
							st_q <= ST_LOGN;
						end
					end
				end
				ST_OFFM: begin
					// one multiply, then restoring divide of (w*|num|+den)/(2den)
					if (den_o <= 0) begin
						if (grp_q == 2'd0) begin
							cok_q <= 1'b0;
							grp_q <= 2'd1;
						end else begin
							pok_q <= 1'b0;
							grp_q <= 2'd2;
							sel_q <= '0;
							step_q <= STEP_LOAD;
							st_q <= ST_FRD;
						end
					end else begin
						dvd_q <= oprod + DivW'(den_o);
						den_q <= 33'(den_o) << 1;
						neg_q <= num_o > 0;
						rem_q <= '0;
						step_q <= '0;
						st_q <= ST_OFFD;
					end
				end
				ST_OFFD, ST_FRD: begin
					if (st_q == ST_FRD && step_q == STEP_LOAD) begin
						// load part<<16 and whole
						dvd_q <= DivW'(fpart) << 16;
						den_q <= 33'(fwhole);
						rem_q <= '0;
						quo_q <= '0;
						step_q <= '0;
					end else begin
						if (!trial[32]) begin
							rem_q <= trial;
							quo_q <= {quo_q[DivW-2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[31:0], dvd_q[DivW-1]};
							quo_q <= {quo_q[DivW-2:0], 1'b0};
						end
						dvd_q <= dvd_q << 1;
						if (step_q == 6'(DivW - 1))
							st_q <= (st_q == ST_OFFD) ? ST_OFFE : ST_FRE;
						step_q <= step_q + 6'd1;
					end
				end
				ST_OFFE: begin
					if (grp_q == 2'd0) co_q <= neg_q ?
						((quo_q > DivW'(32768)) ? -16'sd32768 : 16'(-quo_q)) :
						((quo_q > DivW'(32767)) ? 16'sd32767 : 16'(quo_q));
					else po_q <= neg_q ?
						((quo_q > DivW'(32768)) ? -16'sd32768 : 16'(-quo_q)) :
						((quo_q > DivW'(32767)) ? 16'sd32767 : 16'(quo_q));
					if (grp_q == 2'd0) begin
						grp_q <= 2'd1;
						st_q <= ST_OFFM;
					end else begin
						grp_q <= 2'd2;
						sel_q <= '0;
						step_q <= STEP_LOAD;
						st_q <= ST_FRD;
					end
				end
				ST_FRE: begin
					fr_q[grp_q[0] ? 3'd3 + sel_q : sel_q] <=
						(quo_q > DivW'(65535)) ? 16'hFFFF : quo_q[15:0];
					if (sel_q == 3'd2 && grp_q == 2'd3) begin
						st_q <= ST_OUT;
						out_valid <= 1'b1;
					end else begin
						if (sel_q == 3'd2) begin
							sel_q <= '0;
							grp_q <= 2'd3;
						end else sel_q <= sel_q + 3'd1;
						step_q <= STEP_LOAD;
						st_q <= ST_FRD;
					end
				end
				ST_OUT: begin
					if (out_valid && out_ready) begin
						out_valid <= 1'b0;
						st_q <= ST_IDLE;
						pcnt_q <= '0;
						tot_q <= '0;
						for (int k = 0; k < 3; k++) begin
							ch_q[k] <= '0;
							pk_q[k] <= '0;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	logic [15:0] fl [6];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			fl[k] = (cok_q && ch_q[k] > 0) ? fr_q[k] : 16'd0;
			fl[k+3] = (pok_q && pk_q[k] > 0) ? fr_q[k+3] : 16'd0;
		end
	end

	assign spectrum_valid = pcnt_q >= PCW'(3);
	assign cluster_charge = spectrum_valid ? tot_q : '0;
	assign charge_pos_valid = cok_q;
	assign charge_offset = cok_q ? co_q : '0;
	assign charge_frac_left = fl[0];
	assign charge_frac_mid = fl[1];
	assign charge_frac_right = fl[2];
	assign peak_pos_valid = pok_q;
	assign peak_offset = pok_q ? po_q : '0;
	assign peak_frac_left = fl[3];
	assign peak_frac_mid = fl[4];
	assign peak_frac_right = fl[5];

	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_pv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (charge_pos_valid || peak_pos_valid) |-> spectrum_valid)
		else $error("offset valid without spectrum");
endmodule
